@@ hdl/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg: shared types and codes for the cursor list engine
// Command and status codes plus the control and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Command codes carried on the cmd port.
  localparam logic [3:0] CMD_READ        = 4'd0;
  localparam logic [3:0] CMD_INSERT      = 4'd1;
  localparam logic [3:0] CMD_ATTACH      = 4'd2;
  localparam logic [3:0] CMD_INS_FRONT   = 4'd3;
  localparam logic [3:0] CMD_APPEND      = 4'd4;
  localparam logic [3:0] CMD_START       = 4'd5;
  localparam logic [3:0] CMD_ADVANCE     = 4'd6;
  localparam logic [3:0] CMD_TO_LAST     = 4'd7;
  localparam logic [3:0] CMD_REM_CURRENT = 4'd8;
  localparam logic [3:0] CMD_REM_FRONT   = 4'd9;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOCUR = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture a new request and its decoded effect
    logic up_read;   // read the entry below the gap during an upward shift
    logic up_write;  // write it one place higher
    logic put;       // write the new value into the opened gap
    logic dn_read;   // read the entry above the hole during a downward shift
    logic dn_write;  // write it one place lower
  } cle_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_up;   // the pending request opens a gap
    logic need_dn;   // the pending request closes a hole
    logic up_more;   // entries remain to move up
    logic dn_more;   // entries remain to move down
  } cle_stat_t;

endpackage

@@ hdl/cle_ram.sv @@
// ----------------------------------------------------------------------------
// cle_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/cle_ctrl.sv @@
// ----------------------------------------------------------------------------
// cle_ctrl: sequencer for the cursor list engine
// Walks each request through decode, the entry shift, the final read of the
// current entry and the one-cycle result.
// ----------------------------------------------------------------------------
module cle_ctrl
  import cle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  cle_stat_t stat,
  output cle_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP_RD = 3'd1;
  localparam logic [2:0] S_UP_WR = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_DN_RD = 3'd4;
  localparam logic [2:0] S_DN_WR = 3'd5;
  localparam logic [2:0] S_FETCH = 3'd6;
  localparam logic [2:0] S_SHOW  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.need_up) begin
            state_next = S_UP_RD;
          end else if (stat.need_dn) begin
            state_next = S_DN_RD;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_UP_RD: begin
        if (stat.up_more) begin
          cmd.up_read = 1'b1;
          state_next  = S_UP_WR;
        end else begin
          state_next = S_PUT;
        end
      end
      S_UP_WR: begin
        cmd.up_write = 1'b1;
        state_next   = S_UP_RD;
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_FETCH;
      end
      S_DN_RD: begin
        if (stat.dn_more) begin
          cmd.dn_read = 1'b1;
          state_next  = S_DN_WR;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_DN_WR: begin
        cmd.dn_write = 1'b1;
        state_next   = S_DN_RD;
      end
      S_FETCH: begin
        state_next = S_SHOW;
      end
      S_SHOW: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_SHOW);

endmodule

@@ hdl/cle_dpath.sv @@
// ----------------------------------------------------------------------------
// cle_dpath: datapath of the cursor list engine
// Holds the count, cursor and shift index, decodes each request and drives
// the entry store.
// ----------------------------------------------------------------------------
module cle_dpath
  import cle_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int DATA_WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  cle_cmd_t      cmd,
  output cle_stat_t     stat,
  input  logic [3:0]    cmd_code,
  input  logic [31:0]   entry_value,
  output logic [1:0]    status,
  output logic [31:0]   current_value,
  output logic          has_current,
  output logic [CW-1:0] entry_count,
  output logic [CW-1:0] cursor_pos
);

  logic [CW-1:0]         count;
  logic [CW-1:0]         cursor;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         lim;
  logic [DATA_WIDTH-1:0] value;
  logic [1:0]            status_reg;

  // Decoded effect of the request on the cmd port.
  logic                  cur_ok;
  logic                  full;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         cursor_next;
  logic [1:0]            status_next;
  logic                  up;
  logic                  dn;
  logic [CW-1:0]         last;

  logic [DATA_WIDTH+31:0] value_ext;
  logic [DATA_WIDTH+31:0] read_ext;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic [CW-1:0]         raddr_full;

  assign cur_ok = (cursor < count);
  assign full   = (count == CW'(DEPTH));
  assign last   = count - CW'(1);

  always_comb begin
    pos         = '0;
    count_next  = count;
    cursor_next = cursor;
    status_next = ST_DONE;
    up          = 1'b0;
    dn          = 1'b0;
    case (cmd_code)
      CMD_INSERT, CMD_ATTACH, CMD_INS_FRONT, CMD_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          up         = 1'b1;
          count_next = count + CW'(1);
          case (cmd_code)
            CMD_INSERT: begin
              pos         = cur_ok ? cursor : '0;
              cursor_next = pos;
            end
            CMD_ATTACH: begin
              pos         = cur_ok ? (cursor + CW'(1)) : count;
              cursor_next = pos;
            end
            CMD_INS_FRONT: begin
              pos         = '0;
              cursor_next = '0;
            end
            default: begin
              pos = count;
            end
          endcase
        end
      end
      CMD_START: begin
        cursor_next = '0;
      end
      CMD_ADVANCE: begin
        if (cur_ok) begin
          cursor_next = cursor + CW'(1);
        end else begin
          status_next = ST_NOCUR;
        end
      end
      CMD_TO_LAST: begin
        if (count == '0) begin
          status_next = ST_NOCUR;
        end else begin
          cursor_next = last;
        end
      end
      CMD_REM_CURRENT: begin
        if (cur_ok) begin
          dn         = 1'b1;
          pos        = cursor;
          count_next = last;
        end else begin
          status_next = ST_NOCUR;
        end
      end
      CMD_REM_FRONT: begin
        if (count == '0) begin
          status_next = ST_NOCUR;
        end else begin
          dn          = 1'b1;
          pos         = '0;
          count_next  = last;
          cursor_next = (cursor > last) ? last : cursor;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
    end else if (cmd.load) begin
      count  <= count_next;
      cursor <= cursor_next;
    end
  end

  assign value_ext = {{DATA_WIDTH{1'b0}}, entry_value};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx        <= up ? count : pos;
      lim        <= pos;
      value      <= value_ext[DATA_WIDTH-1:0];
      status_reg <= status_next;
    end else if (cmd.up_write) begin
      idx <= idx - CW'(1);
    end else if (cmd.dn_write) begin
      idx <= idx + CW'(1);
    end
  end

  // During a shift the count already holds the new count, so a downward
  // shift is finished once the index reaches it.
  assign stat.need_up = up;
  assign stat.need_dn = dn;
  assign stat.up_more = (idx > lim);
  assign stat.dn_more = (idx < count);

  always_comb begin
    if (cmd.up_read) begin
      raddr_full = idx - CW'(1);
    end else if (cmd.dn_read) begin
      raddr_full = idx + CW'(1);
    end else begin
      raddr_full = cursor;
    end
  end

  assign raddr = raddr_full[AW-1:0];
  assign we    = cmd.up_write | cmd.dn_write | cmd.put;
  assign waddr = cmd.put ? lim[AW-1:0] : idx[AW-1:0];
  assign wdata = cmd.put ? value : rdata;

  cle_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign read_ext      = {32'd0, rdata};
  assign has_current   = cur_ok;
  assign current_value = cur_ok ? read_ext[31:0] : 32'd0;
  assign status        = status_reg;
  assign entry_count   = count;
  assign cursor_pos    = cursor;

endmodule

@@ hdl/cursor_list_engine.sv @@
// ----------------------------------------------------------------------------
// cursor_list_engine: bounded ordered list with a cursor
// Stores up to DEPTH entries in order, keeps a cursor on the current entry
// and edits, moves or reads the list one request at a time.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   -------   -------------------   ----------------------------------------
//   request   start && !busy        cmd, entry_value
//   result    done (one cycle)      status, current_value, has_current,
//                                   entry_count, cursor_pos
//
// A request that moves no entry goes straight to the read of the current
// entry and the result. An insert first opens a gap by moving entries one
// place up and then writes the new value into it, and a removal closes the
// hole by moving entries one place down. The store is a single RAM with one
// read and one write port and a registered read, so each moved entry is
// read in one step and written back in the next. Reset clears the count and
// the cursor; the store needs no clearing, since only entries below the
// count are ever moved or shown. Busy is high from the cycle after
// acceptance through the cycle of the result, so the next request is taken
// at the earliest in the cycle after the result. The result is shown for
// exactly one cycle with done high; the receiver cannot stall it.
//
module cursor_list_engine
  import cle_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int DATA_WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [3:0]    cmd,
  input  logic [31:0]   entry_value,
  output logic          done,
  output logic [1:0]    status,
  output logic [31:0]   current_value,
  output logic          has_current,
  output logic [CW-1:0] entry_count,
  output logic [CW-1:0] cursor_pos
);

  // The controller sequences each request; the datapath decodes it, keeps
  // the count and cursor, and shifts entries through the store one at a
  // time as the controller steps it.
  cle_cmd_t  ctl;
  cle_stat_t stat;

  cle_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (ctl),
    .busy (busy),
    .done (done)
  );

  cle_dpath #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctl),
    .stat         (stat),
    .cmd_code     (cmd),
    .entry_value  (entry_value),
    .status       (status),
    .current_value(current_value),
    .has_current  (has_current),
    .entry_count  (entry_count),
    .cursor_pos   (cursor_pos)
  );

endmodule
